>>> sv/bbc_pkg.sv
`timescale 1ns / 1ps
package bbc_pkg;
	localparam int SLOTS = 32;
	localparam int SLOT_W = 5;
	localparam int CNT_W = 6;
	localparam int BLK_W = 24;

	localparam logic [1:0] CMD_READ = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_SYNC = 2'd2;
	localparam logic [1:0] CMD_RSVD = 2'd3;

	localparam logic [2:0] ACT_RD_HIT = 3'd0;
	localparam logic [2:0] ACT_RD_FILL = 3'd1;
	localparam logic [2:0] ACT_WR_HIT = 3'd2;
	localparam logic [2:0] ACT_WR_ALLOC = 3'd3;
	localparam logic [2:0] ACT_WB = 3'd4;
	localparam logic [2:0] ACT_SYNC_DONE = 3'd5;

	localparam logic REG_LOW_MARK = 1'b0;
	localparam logic REG_REFILL_MARK = 1'b1;

	// datapath operation requested by the controller
	typedef enum logic [3:0] {
		OP_NONE = 4'd0,
		OP_EVICT = 4'd1,
		OP_HIT = 4'd2,
		OP_ALLOC = 4'd3,
		OP_SYNC_WB = 4'd4
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic write;
	} dp_cmd_t;

	typedef struct packed {
		logic any_valid;
		logic lru_dirty;
		logic hit;
		logic any_dirty;
		logic [CNT_W-1:0] free_count;
		logic [SLOT_W-1:0] lru_slot;
		logic [BLK_W-1:0] lru_tag;
		logic [SLOT_W-1:0] hit_slot;
		logic [SLOT_W-1:0] first_dirty;
		logic [BLK_W-1:0] first_dirty_tag;
		logic [SLOT_W-1:0] free_slot;
	} dp_status_t;
endpackage

>>> sv/bbc_datapath.sv
`timescale 1ns / 1ps
module bbc_datapath
	import bbc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input dp_cmd_t cmd,
	input logic [BLK_W-1:0] blk,
	output dp_status_t status
);
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] dirty_q;
	logic [BLK_W-1:0] tag_q [SLOTS];
	logic [SLOT_W-1:0] rank_q [SLOTS];
	logic [SLOT_W-1:0] dord_q [SLOTS];
	logic [SLOT_W-1:0] fifo_q [SLOTS];
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0] free_q;
	logic [CNT_W-1:0] dcnt_q;

	logic hit;
	logic [SLOT_W-1:0] hit_slot;
	logic [SLOT_W-1:0] lru_slot;
	logic [SLOT_W-1:0] fd_slot;
	logic [SLOT_W-1:0] tgt;
	logic [SLOT_W-1:0] tgt_rank;
	logic [SLOT_W-1:0] tgt_dord;
	logic tgt_dirty;
	logic [SLOT_W-1:0] tail;

	// priority searches; ranks of valid slots are distinct, the LRU rank is the count-1
	always_comb begin
		hit = 1'b0;
		hit_slot = '0;
		lru_slot = '0;
		fd_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == blk) begin
				hit = 1'b1;
				hit_slot = SLOT_W'(i);
			end
			if (valid_q[i] && rank_q[i] == 5'(CNT_W'(SLOTS) - free_q - 6'd1))
				lru_slot = SLOT_W'(i);
			if (dirty_q[i] && dord_q[i] == '0)
				fd_slot = SLOT_W'(i);
		end
	end

	always_comb begin
		unique case (cmd.op)
			OP_EVICT: tgt = lru_slot;
			OP_HIT: tgt = hit_slot;
			OP_ALLOC: tgt = fifo_q[head_q];
			OP_SYNC_WB: tgt = fd_slot;
			default: tgt = '0;
		endcase
	end

	assign tgt_rank = rank_q[tgt];
	assign tgt_dord = dord_q[tgt];
	assign tgt_dirty = dirty_q[tgt];
	assign tail = head_q + free_q[SLOT_W-1:0];

	assign status.any_valid = |valid_q;
	assign status.lru_dirty = dirty_q[lru_slot];
	assign status.hit = hit;
	assign status.any_dirty = |dirty_q;
	assign status.free_count = free_q;
	assign status.lru_slot = lru_slot;
	assign status.lru_tag = tag_q[lru_slot];
	assign status.hit_slot = hit_slot;
	assign status.first_dirty = fd_slot;
	assign status.first_dirty_tag = tag_q[fd_slot];
	assign status.free_slot = fifo_q[head_q];

	// slot state update, one operation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			head_q <= '0;
			free_q <= CNT_W'(SLOTS);
			dcnt_q <= '0;
			for (int i = 0; i < SLOTS; i++) fifo_q[i] <= SLOT_W'(i);
		end else begin
			case (cmd.op) inside
				OP_EVICT, OP_SYNC_WB: begin
					if (tgt_dirty) begin
						for (int i = 0; i < SLOTS; i++)
							if (dirty_q[i] && dord_q[i] > tgt_dord)
								dord_q[i] <= dord_q[i] - 5'd1;
						dirty_q[tgt] <= 1'b0;
						dcnt_q <= dcnt_q - 6'd1;
					end
					if (cmd.op == OP_EVICT) begin
						valid_q[tgt] <= 1'b0;
						fifo_q[tail] <= tgt;
						free_q <= free_q + 6'd1;
					end
				end
				OP_HIT: begin
					for (int i = 0; i < SLOTS; i++)
						if (valid_q[i] && rank_q[i] < tgt_rank)
							rank_q[i] <= rank_q[i] + 5'd1;
					rank_q[tgt] <= '0;
					if (cmd.write && !tgt_dirty) begin
						dirty_q[tgt] <= 1'b1;
						dord_q[tgt] <= dcnt_q[SLOT_W-1:0];
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				OP_ALLOC: begin
					for (int i = 0; i < SLOTS; i++)
						if (valid_q[i]) rank_q[i] <= rank_q[i] + 5'd1;
					rank_q[tgt] <= '0;
					valid_q[tgt] <= 1'b1;
					tag_q[tgt] <= blk;
					head_q <= head_q + 5'd1;
					free_q <= free_q - 6'd1;
					if (cmd.write) begin
						dirty_q[tgt] <= 1'b1;
						dord_q[tgt] <= dcnt_q[SLOT_W-1:0];
						dcnt_q <= dcnt_q + 6'd1;
					end
				end
				default: ;
			endcase
		end
	end

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= CNT_W'(SLOTS)) else $error("free count out of range");
	a_dirty_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dirty_q & ~valid_q) == '0) else $error("dirty slot not valid");
	a_dcnt: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q == CNT_W'($countones(dirty_q))) else $error("dirty count mismatch");
	a_free_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		free_q == CNT_W'(SLOTS - $countones(valid_q))) else $error("free count mismatch");
endmodule

>>> sv/bbc_ctrl.sv
`timescale 1ns / 1ps
module bbc_ctrl
	import bbc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] in_cmd,
	input logic [BLK_W-1:0] in_blk,
	input logic [CNT_W-1:0] low_mark,
	input logic [CNT_W-1:0] refill_mark,
	input dp_status_t status,
	output dp_cmd_t dp_cmd,
	output logic [BLK_W-1:0] blk,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] out_action,
	output logic [BLK_W-1:0] out_block,
	output logic [SLOT_W-1:0] out_slot,
	output logic out_last
);
	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CHECK = 5'b00010,
		ST_EVICT = 5'b00100,
		ST_LOOKUP = 5'b01000,
		ST_SYNC = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [1:0] cmd_q;
	logic [BLK_W-1:0] blk_q;
	logic out_free;
	logic emit;
	logic [2:0] act_d;
	logic [BLK_W-1:0] oblk_d;
	logic [SLOT_W-1:0] oslot_d;
	logic last_d;

	assign blk = blk_q;
	assign out_free = !out_valid || out_ready;
	assign in_ready = state_q == ST_IDLE;

	// sequencer: each step updates state and may emit one transfer
	always_comb begin
		state_d = state_q;
		dp_cmd.op = OP_NONE;
		dp_cmd.write = cmd_q == CMD_WRITE;
		emit = 1'b0;
		act_d = ACT_WB;
		oblk_d = status.lru_tag;
		oslot_d = status.lru_slot;
		last_d = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_CHECK: begin
				if (cmd_q == CMD_SYNC) state_d = ST_SYNC;
				else if (status.free_count == low_mark) state_d = ST_EVICT;
				else state_d = ST_LOOKUP;
			end
			ST_EVICT: begin
				if (!status.any_valid) state_d = ST_LOOKUP;
				else if (out_free) begin
					dp_cmd.op = OP_EVICT;
					emit = status.lru_dirty;
					if (status.free_count + 6'd1 >= refill_mark) state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (out_free) begin
					last_d = 1'b1;
					if (status.hit) begin
						dp_cmd.op = OP_HIT;
						emit = 1'b1;
						act_d = cmd_q == CMD_WRITE ? ACT_WR_HIT : ACT_RD_HIT;
						oblk_d = blk_q;
						oslot_d = status.hit_slot;
						state_d = ST_IDLE;
					end else if (status.free_count == '0) begin
						// full cache: make room first
						dp_cmd.op = OP_EVICT;
						emit = status.lru_dirty;
						last_d = 1'b0;
					end else begin
						dp_cmd.op = OP_ALLOC;
						emit = 1'b1;
						act_d = cmd_q == CMD_WRITE ? ACT_WR_ALLOC : ACT_RD_FILL;
						oblk_d = blk_q;
						oslot_d = status.free_slot;
						state_d = ST_IDLE;
					end
				end
			end
			ST_SYNC: begin
				if (out_free) begin
					emit = 1'b1;
					if (status.any_dirty) begin
						dp_cmd.op = OP_SYNC_WB;
						oblk_d = status.first_dirty_tag;
						oslot_d = status.first_dirty;
					end else begin
						act_d = ACT_SYNC_DONE;
						oblk_d = '0;
						oslot_d = '0;
						last_d = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && in_valid && in_cmd != CMD_RSVD) state_d = ST_CHECK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// request and output registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q <= in_cmd;
			blk_q <= in_blk;
		end
		if (emit) begin
			out_action <= act_d;
			out_block <= oblk_d;
			out_slot <= oslot_d;
			out_last <= last_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free) else $error("result overwritten");
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_d) |=> state_q == ST_IDLE) else $error("last without idle");
	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("state not one-hot");
endmodule

>>> sv/block_buffer_cache_lru_core.sv
`timescale 1ns / 1ps
// LRU write-back cache tag controller, 32 slots, fully associative. One request at a time:
// a read/write passes through the CHECK and LOOKUP states, plus one step per eviction
// step (each slot evicted in a run, the forced eviction of a miss on a full cache, and one
// for a run that finds no valid slot left); a sync passes through CHECK and one SYNC step
// per dirty slot plus a final one. Each step that emits may wait on the output register
// (s_tready stays low while busy).
// Results carry last on the final transfer of a request; command code 3 is dropped.
module block_buffer_cache_lru_core
	import bbc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [31:0] s_tdata, // [1:0] cmd, [25:2] block_number, zero fill
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata, // [2:0] action, [26:3] result_block, [31:27] slot
	output logic m_tlast,
	input logic cfg_we,
	input logic cfg_index,
	input logic [CNT_W-1:0] cfg_wdata
);
	logic [CNT_W-1:0] low_q, refill_q;
	dp_cmd_t dp_cmd;
	dp_status_t status;
	logic [BLK_W-1:0] blk;
	logic [2:0] action;
	logic [BLK_W-1:0] oblk;
	logic [SLOT_W-1:0] oslot;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= 6'd3;
			refill_q <= 6'd9;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_MARK: low_q <= cfg_wdata;
				REG_REFILL_MARK: refill_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	bbc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_cmd(s_tdata[1:0]), .in_blk(s_tdata[25:2]),
		.low_mark(low_q), .refill_mark(refill_q),
		.status, .dp_cmd, .blk,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_action(action), .out_block(oblk), .out_slot(oslot), .out_last(m_tlast)
	);

	bbc_datapath u_dp (
		.clk, .arst_n, .cmd(dp_cmd), .blk, .status
	);

	assign m_tdata = {oslot, oblk, action};
endmodule
